/* design/scvd_pkg.sv */
// Shared types and constants for the sparse count vector decoder.
// No dependencies; used by every module of the decoder.
`default_nettype none

package scvd_pkg;

  localparam int unsigned KEY_SLOTS_DEFAULT = 256;
  localparam int unsigned HEADER_BYTES      = 3;
  localparam int unsigned ENTRY_BYTES       = 6;
  localparam int unsigned POS_W             = 19;
  localparam int unsigned SUB_W             = 3;
  localparam int unsigned KEY_W             = 16;
  localparam int unsigned COUNT_W           = 32;
  localparam int unsigned EPOCH_W           = 8;

  localparam logic [POS_W-1:0] POS_MAX        = '1;
  localparam logic [7:0]       VERSION_RESET  = 8'd1;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_SHORT     = 3'd1,
    STATUS_VERSION   = 3'd2,
    STATUS_LENGTH    = 3'd3,
    STATUS_BAD_KEY   = 3'd4,
    STATUS_ZERO      = 3'd5
  } status_e;

  typedef enum logic {
    KIND_ENTRY  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    status_e            status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic             lookup;
    logic             mark;
    logic             msg_end;
    logic [KEY_W-1:0] key;
  } seen_req_t;

endpackage

`default_nettype wire

/* design/sparse_count_vector_decoder_core.sv */
// Top level of the sparse count vector decoder: byte parser and entry checks.
// Depends on scvd_pkg, scvd_key_seen and scvd_result_queue.
//
// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   data_byte_i, end_of_message_i
// output    out_valid_o / out_ready_i result_kind_o, key_number_o, count_value_o,
//                                     status_code_o, last_result_o
// config    format_version_we_i       format_version_i
//
// One byte beat is taken per cycle while the key memory is idle and the queue has room;
// its results are registered in the result queue. A four-slot result queue lets bytes
// flow while up to two results wait. After reset, and after every 255th message, the key
// memory runs a clearing pass over all KEY_SLOTS slots during which no byte is taken.
// A stalled output only stops input once fewer than two queue slots are free.
`default_nettype none

module sparse_count_vector_decoder_core #(
  parameter int unsigned KEY_SLOTS = scvd_pkg::KEY_SLOTS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        format_version_we_i,
  input  wire logic [7:0]  format_version_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic [15:0]      key_number_o,
  output logic [31:0]      count_value_o,
  output logic [2:0]       status_code_o,
  output logic             last_result_o
);

  localparam int unsigned POS_W = scvd_pkg::POS_W;
  localparam logic [POS_W-1:0] HDR = POS_W'(scvd_pkg::HEADER_BYTES);
  localparam logic [scvd_pkg::SUB_W-1:0] SUB_LAST =
    scvd_pkg::SUB_W'(scvd_pkg::ENTRY_BYTES - 1);

  logic [7:0]                   fmt_q;
  logic [POS_W-1:0]             pos_q, pos_d;
  logic [15:0]                  decl_q, decl_d;
  logic                         vm_q, vm_d;
  logic [scvd_pkg::SUB_W-1:0]   sub_q, sub_d;
  logic [15:0]                  ent_q, ent_d;
  scvd_pkg::status_e            err_q, err_d;
  logic [39:0]                  sh_q;

  logic                         acc;
  logic                         in_body;
  logic                         vm_now;
  logic [15:0]                  decl_now;
  logic [15:0]                  entry_key;
  logic [31:0]                  entry_cnt;
  logic                         key_in_range;
  logic                         emit;
  logic [POS_W-1:0]             pos_inc;
  logic [POS_W-1:0]             expected;
  scvd_pkg::status_e            status;
  logic                         seen;
  logic                         busy;
  logic                         room;
  scvd_pkg::seen_req_t          seen_req;
  scvd_pkg::result_t            entry_res, status_res, first_res, out_res;

  assign in_ready_o = room & ~busy;
  assign acc        = in_valid_i & in_ready_o;

  always_comb begin
    vm_now   = (pos_q == '0) ? (data_byte_i == fmt_q) : vm_q;
    decl_now = decl_q;
    if (pos_q == POS_W'(1)) begin
      decl_now = {decl_q[15:8], data_byte_i};
    end else if (pos_q == POS_W'(2)) begin
      decl_now = {data_byte_i, decl_q[7:0]};
    end
    in_body      = (pos_q >= HDR) && (pos_q != scvd_pkg::POS_MAX) && (ent_q < decl_q);
    entry_key    = sh_q[15:0];
    entry_cnt    = {data_byte_i, sh_q[39:16]};
    key_in_range = {1'b0, entry_key} < 17'(KEY_SLOTS);

    err_d = err_q;
    emit  = 1'b0;
    if (in_body && (sub_q == SUB_LAST) && vm_q && (err_q == scvd_pkg::STATUS_OK)) begin
      if (!key_in_range || seen) begin
        err_d = scvd_pkg::STATUS_BAD_KEY;
      end else if (entry_cnt == '0) begin
        err_d = scvd_pkg::STATUS_ZERO;
      end else begin
        emit = 1'b1;
      end
    end

    pos_inc  = (pos_q == scvd_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
    expected = HDR + POS_W'({decl_now, 2'b00}) + POS_W'({decl_now, 1'b0});
    if (pos_inc < HDR) begin
      status = scvd_pkg::STATUS_SHORT;
    end else if (!vm_now) begin
      status = scvd_pkg::STATUS_VERSION;
    end else if (pos_inc != expected) begin
      status = scvd_pkg::STATUS_LENGTH;
    end else begin
      status = err_d;
    end

    pos_d  = pos_inc;
    decl_d = decl_now;
    vm_d   = vm_now;
    sub_d  = sub_q;
    ent_d  = ent_q;
    if (in_body) begin
      if (sub_q == SUB_LAST) begin
        sub_d = '0;
        ent_d = ent_q + 1'b1;
      end else begin
        sub_d = sub_q + 1'b1;
      end
    end
    if (end_of_message_i) begin
      pos_d  = '0;
      decl_d = '0;
      vm_d   = 1'b0;
      sub_d  = '0;
      ent_d  = '0;
      err_d  = scvd_pkg::STATUS_OK;
    end
  end

  always_comb begin
    seen_req.lookup  = acc & in_body & (sub_q == scvd_pkg::SUB_W'(1));
    seen_req.mark    = acc & emit;
    seen_req.msg_end = acc & end_of_message_i;
    seen_req.key     = seen_req.lookup ? {data_byte_i, sh_q[39:32]} : entry_key;
  end

  always_comb begin
    entry_res.kind    = scvd_pkg::KIND_ENTRY;
    entry_res.key     = entry_key;
    entry_res.count   = entry_cnt;
    entry_res.status  = scvd_pkg::STATUS_OK;
    entry_res.last    = 1'b0;
    status_res.kind   = scvd_pkg::KIND_STATUS;
    status_res.key    = '0;
    status_res.count  = '0;
    status_res.status = status;
    status_res.last   = 1'b1;
    first_res         = emit ? entry_res : status_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= scvd_pkg::VERSION_RESET;
      pos_q  <= '0;
      decl_q <= '0;
      vm_q   <= 1'b0;
      sub_q  <= '0;
      ent_q  <= '0;
      err_q  <= scvd_pkg::STATUS_OK;
    end else begin
      if (format_version_we_i) begin
        fmt_q <= format_version_i;
      end
      if (acc) begin
        pos_q  <= pos_d;
        decl_q <= decl_d;
        vm_q   <= vm_d;
        sub_q  <= sub_d;
        ent_q  <= ent_d;
        err_q  <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_body) begin
      sh_q <= {data_byte_i, sh_q[39:8]};
    end
  end

  scvd_key_seen #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_key_seen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (seen_req),
    .seen_o (seen),
    .busy_o (busy)
  );

  scvd_result_queue u_result_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_first_i  (acc & (emit | end_of_message_i)),
    .push_second_i (acc & emit & end_of_message_i),
    .first_i       (first_res),
    .second_i      (status_res),
    .pop_ready_i   (out_ready_i),
    .room_o        (room),
    .out_valid_o   (out_valid_o),
    .out_o         (out_res)
  );

  assign result_kind_o = out_res.kind;
  assign key_number_o  = out_res.key;
  assign count_value_o = out_res.count;
  assign status_code_o = out_res.status;
  assign last_result_o = out_res.last;

endmodule

`default_nettype wire

/* design/scvd_key_seen.sv */
// Per-message key bitmap kept as an epoch-tagged memory with a clearing pass.
// Depends on scvd_pkg.
`default_nettype none

module scvd_key_seen #(
  parameter int unsigned KEY_SLOTS = scvd_pkg::KEY_SLOTS_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire scvd_pkg::seen_req_t req_i,
  output logic                    seen_o,
  output logic                    busy_o
);

  localparam int unsigned IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(KEY_SLOTS - 1);
  localparam logic [scvd_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [scvd_pkg::EPOCH_W-1:0] EPOCH_FIRST = scvd_pkg::EPOCH_W'(1);

  logic [scvd_pkg::EPOCH_W-1:0] mem [KEY_SLOTS];
  logic [scvd_pkg::EPOCH_W-1:0] rd_q;
  logic [scvd_pkg::EPOCH_W-1:0] epoch_q;
  logic                         busy_q;
  logic [IDX_W-1:0]             clr_q;
  logic [IDX_W-1:0]             idx;
  logic                         in_range;

  assign idx      = req_i.key[IDX_W-1:0];
  assign in_range = {1'b0, req_i.key} < (scvd_pkg::KEY_W + 1)'(KEY_SLOTS);
  assign seen_o   = (rd_q == epoch_q);
  assign busy_o   = busy_q;

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (req_i.mark && in_range) begin
      mem[idx] <= epoch_q;
    end
    if (req_i.lookup && in_range) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      clr_q   <= '0;
      epoch_q <= EPOCH_FIRST;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == IDX_LAST) begin
        busy_q <= 1'b0;
      end
    end else if (req_i.msg_end) begin
      if (epoch_q == EPOCH_MAX) begin
        epoch_q <= EPOCH_FIRST;
        busy_q  <= 1'b1;
        clr_q   <= '0;
      end else begin
        epoch_q <= epoch_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/scvd_result_queue.sv */
// Four-slot result queue that takes up to two results per beat.
// Depends on scvd_pkg.
`default_nettype none

module scvd_result_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_first_i,
  input  wire logic             push_second_i,
  input  wire scvd_pkg::result_t first_i,
  input  wire scvd_pkg::result_t second_i,
  input  wire logic             pop_ready_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  output scvd_pkg::result_t     out_o
);

  scvd_pkg::result_t slots_q [4];
  logic [1:0] wr_q;
  logic [1:0] rd_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [2:0] cnt_d;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_o       = slots_q[rd_q];
  assign room_o      = (cnt_q <= 3'd2);
  assign pop         = out_valid_o & pop_ready_i;
  assign cnt_d       = cnt_q + {2'b00, push_first_i} + {2'b00, push_second_i}
                       - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_first_i) begin
      slots_q[wr_q] <= first_i;
    end
    if (push_second_i) begin
      slots_q[wr_q + 2'd1] <= second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + {1'b0, push_first_i} + {1'b0, push_second_i};
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire
